### rtl/wesd_pkg.sv
// Package for the windowed energy silence detector.
// Shared widths, register codes, reset values and the structs passed between modules.
// No dependencies.
package wesd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int SUM_W = SAMPLE_BITS + 1;
   localparam int SQ_W = 2 * SAMPLE_BITS + 1;
   localparam int ENERGY_W = 48;
   localparam int FILL_W = 16;
   localparam int MIN_W = 32;
   localparam int OUT_W = 32;
   localparam int FRAME_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic              STEREO_MODE_RESET = 1'b1;
   localparam logic [FILL_W-1:0] WINDOW_LEN_RESET = 16'd4800;
   localparam logic [ENERGY_W-1:0] ENERGY_THRESHOLD_RESET = 48'd2061584302;
   localparam logic [MIN_W-1:0]  MIN_SILENCE_RESET = 32'd24000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STEREO_MODE      = 2'd0,
      CSR_WINDOW_LEN       = 2'd1,
      CSR_ENERGY_THRESHOLD = 2'd2,
      CSR_MIN_SILENCE      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                stereo_mode;
      logic [FILL_W-1:0]   window_len;
      logic [ENERGY_W-1:0] energy_threshold;
      logic [MIN_W-1:0]    min_silence_frames;
   } wesd_cfg_type;

   // one queued frame: channel sum (half-LSB units) and end-of-clip mark
   typedef struct packed {
      logic signed [SUM_W-1:0] chan_sum;
      logic                    last_frame;
   } wesd_entry_type;

   typedef struct packed {
      logic sq_valid;
      logic update_fire;
      logic out_stall;
   } wesd_back_status_type;

endpackage

### rtl/wesd_front.sv
// Front end: accepts frames and forms the channel sum into a holding register.
// Depends on wesd_pkg.
module wesd_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  stereo_mode,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [wesd_pkg::SAMPLE_BITS-1:0] left_sample,
   input  logic signed [wesd_pkg::SAMPLE_BITS-1:0] right_sample,
   input  logic                                  last_frame,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output wesd_pkg::wesd_entry_type              push_entry
);
   import wesd_pkg::*;

   logic                    valid_ff, valid_in;
   wesd_entry_type          entry_ff, entry_in;
   logic signed [SUM_W-1:0] left_ext, right_ext;

   assign left_ext  = $signed({left_sample[SAMPLE_BITS-1], left_sample});
   assign right_ext = $signed({right_sample[SAMPLE_BITS-1], right_sample});

   assign in_ready = !valid_ff || push_ready;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (push_ready) begin
         valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         entry_in.chan_sum   = stereo_mode ? (left_ext + right_ext) : (left_ext + left_ext);
         entry_in.last_frame = last_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

### rtl/wesd_queue.sv
// Short frame queue between front and back end, register based.
// Depends on wesd_pkg.
module wesd_queue #(
   parameter int DEPTH = wesd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   output logic                          push_ready,
   input  wesd_pkg::wesd_entry_type      push_entry,
   output logic                          pop_valid,
   input  logic                          pop_ready,
   output wesd_pkg::wesd_entry_type      pop_entry,
   output logic [$clog2(DEPTH+1)-1:0]    level
);
   import wesd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wesd_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign level      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/wesd_back.sv
// Back end: squares the channel sum, accumulates window energy, tracks silent runs
// and holds the result in an output register. Depends on wesd_pkg.
module wesd_back #(
   parameter int FRAME_BITS = wesd_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wesd_pkg::wesd_cfg_type            cfg,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  wesd_pkg::wesd_entry_type          pop_entry,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [wesd_pkg::OUT_W-1:0]        seg_start,
   output logic [wesd_pkg::OUT_W-1:0]        seg_end,
   output logic                              at_clip_end,
   output wesd_pkg::wesd_back_status_type    status
);
   import wesd_pkg::*;

   localparam int CMP_W = (FRAME_BITS > MIN_W) ? FRAME_BITS : MIN_W;

   function automatic logic [OUT_W-1:0] to_out(input logic [FRAME_BITS-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      return w[OUT_W-1:0];
   endfunction

   // square stage
   logic [SUM_W-1:0]   mag;
   logic [2*SUM_W-1:0] prod;
   logic               sq_valid_ff, sq_valid_in;
   logic [SQ_W-1:0]    sq_ff;
   logic               sq_last_ff;
   logic               fire;

   // detector state
   logic [ENERGY_W-1:0]   energy_ff, energy_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [FRAME_BITS-1:0] wstart_ff, wstart_in;
   logic                  insil_ff, insil_in;
   logic [FRAME_BITS-1:0] rstart_ff, rstart_in;

   logic [ENERGY_W:0]     energy_sum;
   logic [ENERGY_W-1:0]   energy_acc;
   logic [FILL_W-1:0]     fill_inc;
   logic                  win_close, silent;
   logic [FRAME_BITS-1:0] frame_inc, loud_len, trail_len;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]      seg_start_ff, seg_start_in, seg_end_ff, seg_end_in;
   logic                  at_end_ff, at_end_in;
   logic                  emit;

   assign mag  = pop_entry.chan_sum[SUM_W-1] ? $unsigned(-pop_entry.chan_sum)
                                              : $unsigned(pop_entry.chan_sum);
   assign prod = (2*SUM_W)'(mag) * (2*SUM_W)'(mag);

   assign fire      = sq_valid_ff && (!out_valid_ff || out_ready);
   assign pop_ready = !sq_valid_ff || fire;

   always_comb begin
      sq_valid_in = sq_valid_ff;
      if (fire) begin
         sq_valid_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         sq_valid_in = 1'b1;
      end
   end

   // saturating accumulate, window close and threshold test
   assign energy_sum = {1'b0, energy_ff} + (ENERGY_W + 1)'(sq_ff);
   assign energy_acc = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
   assign fill_inc   = fill_ff + FILL_W'(1);
   assign win_close  = (fill_inc >= cfg.window_len);
   assign silent     = (energy_acc < cfg.energy_threshold);
   assign frame_inc  = frame_ff + FRAME_BITS'(1);
   assign loud_len   = wstart_ff - rstart_ff;

   always_comb begin
      energy_in    = energy_ff;
      fill_in      = fill_ff;
      frame_in     = frame_ff;
      wstart_in    = wstart_ff;
      insil_in     = insil_ff;
      rstart_in    = rstart_ff;
      emit         = 1'b0;
      seg_start_in = seg_start_ff;
      seg_end_in   = seg_end_ff;
      at_end_in    = at_end_ff;
      trail_len    = frame_inc - rstart_ff;
      if (fire) begin
         if (win_close) begin
            if (silent) begin
               if (!insil_ff) begin
                  insil_in  = 1'b1;
                  rstart_in = wstart_ff;
               end
            end else if (insil_ff) begin
               if (CMP_W'(loud_len) >= CMP_W'(cfg.min_silence_frames)) begin
                  emit         = 1'b1;
                  seg_start_in = to_out(rstart_ff);
                  seg_end_in   = to_out(wstart_ff);
                  at_end_in    = 1'b0;
               end
               insil_in = 1'b0;
            end
            energy_in = '0;
            fill_in   = '0;
            wstart_in = frame_inc;
         end else begin
            energy_in = energy_acc;
            fill_in   = fill_inc;
         end
         frame_in  = frame_inc;
         trail_len = frame_inc - rstart_in;
         // end of clip: flush a trailing run, then clear the detector state
         if (sq_last_ff) begin
            if (insil_in && (CMP_W'(trail_len) >= CMP_W'(cfg.min_silence_frames))) begin
               emit         = 1'b1;
               seg_start_in = to_out(rstart_in);
               seg_end_in   = to_out(frame_inc);
               at_end_in    = 1'b1;
            end
            energy_in = '0;
            fill_in   = '0;
            frame_in  = '0;
            wstart_in = '0;
            insil_in  = 1'b0;
            rstart_in = '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = emit;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         energy_ff    <= '0;
         fill_ff      <= '0;
         frame_ff     <= '0;
         wstart_ff    <= '0;
         insil_ff     <= 1'b0;
         rstart_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= sq_valid_in;
         energy_ff    <= energy_in;
         fill_ff      <= fill_in;
         frame_ff     <= frame_in;
         wstart_ff    <= wstart_in;
         insil_ff     <= insil_in;
         rstart_ff    <= rstart_in;
         out_valid_ff <= out_valid_in;
      end
      if (pop_valid && pop_ready) begin
         sq_ff      <= prod[SQ_W-1:0];
         sq_last_ff <= pop_entry.last_frame;
      end
      seg_start_ff <= seg_start_in;
      seg_end_ff   <= seg_end_in;
      at_end_ff    <= at_end_in;
   end

   assign out_valid   = out_valid_ff;
   assign seg_start   = seg_start_ff;
   assign seg_end     = seg_end_ff;
   assign at_clip_end = at_end_ff;
   assign status      = '{sq_valid: sq_valid_ff, update_fire: fire,
                          out_stall: out_valid_ff && !out_ready};

endmodule

### rtl/windowed_energy_silence_detector_core.sv
// Top level of the windowed energy silence detector: register file and the
// front end, frame queue and back end. Depends on wesd_pkg, wesd_front,
// wesd_queue and wesd_back.
//
// Use:
//   req_* stream: one PCM frame per transaction. tdata holds left_sample
//   (bits 15:0) and right_sample (bits 31:16), tlast marks the last frame
//   of a clip and flushes a trailing silent run.
//   rsp_* stream: one transaction per reported silent run. tdata holds
//   seg_start (31:0) and seg_end (63:32); tuser is at_clip_end.
//   csr_*: write-only registers, taken on any edge with csr_we high. Write
//   them only while no frame is in flight.
// Path: an accepted frame passes the front register, a queue slot and the square
// register before the detector state takes it; a run it closes shows on
// rsp_tvalid from the edge at which the detector state takes that frame.
// Throughput: one frame per cycle while the receiver takes each report; the
// saturating accumulate and threshold compare in the back end are combinational.
// Reset (synchronous, active high) restores register defaults, clears the
// detector state and empties the pipeline; no clearing sweep is needed.
// Receiver stall: the result stays in the output register, the back end
// holds, the queue fills, and req_tready drops once it and the front
// register are full.
module windowed_energy_silence_detector_core #(
   parameter int FRAME_BITS  = wesd_pkg::FRAME_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = wesd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration write port
   input  logic                            csr_we,
   input  logic [wesd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [wesd_pkg::CSR_DATA_W-1:0] csr_wdata,
   // frame stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [2*wesd_pkg::SAMPLE_BITS-1:0] req_tdata, // left_sample, right_sample
   input  logic                            req_tlast,    // last_frame
   // run report stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [2*wesd_pkg::OUT_W-1:0]    rsp_tdata,    // seg_start, seg_end
   output logic                            rsp_tuser     // at_clip_end
);
   import wesd_pkg::*;

   wesd_cfg_type         cfg_ff, cfg_in;
   logic                 push_valid, push_ready, pop_valid, pop_ready;
   wesd_entry_type       push_entry, pop_entry;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_level;
   wesd_back_status_type back_status;
   logic [OUT_W-1:0]     seg_start, seg_end;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_STEREO_MODE:      cfg_in.stereo_mode        = csr_wdata[0];
            CSR_WINDOW_LEN:       cfg_in.window_len         = csr_wdata[FILL_W-1:0];
            CSR_ENERGY_THRESHOLD: cfg_in.energy_threshold   = csr_wdata[ENERGY_W-1:0];
            CSR_MIN_SILENCE:      cfg_in.min_silence_frames = csr_wdata[MIN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{stereo_mode: STEREO_MODE_RESET, window_len: WINDOW_LEN_RESET,
                     energy_threshold: ENERGY_THRESHOLD_RESET,
                     min_silence_frames: MIN_SILENCE_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wesd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .stereo_mode  (cfg_ff.stereo_mode),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .left_sample  ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .right_sample ($signed(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
      .last_frame   (req_tlast),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_entry   (push_entry)
   );

   wesd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .level      (queue_level)
   );

   wesd_back #(.FRAME_BITS(FRAME_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .seg_start   (seg_start),
      .seg_end     (seg_end),
      .at_clip_end (rsp_tuser),
      .status      (back_status)
   );

   assign rsp_tdata = {seg_end, seg_start};

   // checks
   a_reset_clears_output: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && (queue_level == '0))
      else $error("pipeline not empty after reset");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue level beyond depth");

   a_square_holds: assert property (@(posedge clock) disable iff (reset)
      back_status.sq_valid && !back_status.update_fire |=> back_status.sq_valid)
      else $error("squared frame lost while back end stalled");

   a_no_update_on_stall: assert property (@(posedge clock) disable iff (reset)
      back_status.out_stall |-> !back_status.update_fire)
      else $error("detector advanced while result still pending");

endmodule

### tb/sv/wesd_run_checker.sv
// Run-report checker for the windowed energy silence detector.
// Mirrors the register file, predicts reports for accepted frames, compares rsp transactions.
// Depends on wesd_pkg.
module wesd_run_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [wesd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [wesd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [2*wesd_pkg::SAMPLE_BITS-1:0] req_tdata,  // left_sample, right_sample
   input  logic                               req_tlast,  // last_frame
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [2*wesd_pkg::OUT_W-1:0]       rsp_tdata,  // seg_start, seg_end
   input  logic                               rsp_tuser,  // at_clip_end
   output int                                 error_count,
   output int                                 reports_due
);
   import wesd_pkg::*;

   localparam int FRAME_W = FRAME_BITS_DEFAULT;
   localparam logic [ENERGY_W-1:0] ENERGY_FULL = '1;

   typedef struct packed {
      logic [OUT_W-1:0] seg_start;
      logic [OUT_W-1:0] seg_end;
      logic             at_clip_end;
   } run_report_type;

   logic                cfg_stereo;
   logic [FILL_W-1:0]   cfg_window_len;
   logic [ENERGY_W-1:0] cfg_threshold;
   logic [MIN_W-1:0]    cfg_min_run;

   logic [ENERGY_W-1:0] acc_energy;
   logic [FILL_W-1:0]   acc_fill;
   logic [FRAME_W-1:0]  frame_no;
   logic [FRAME_W-1:0]  win_first;
   logic                silent;
   logic [FRAME_W-1:0]  run_first;

   run_report_type silent_runs_due[$];
   int             mismatches = 0;

   task automatic clear_detector();
      acc_energy = '0;
      acc_fill   = '0;
      frame_no   = '0;
      win_first  = '0;
      silent     = 1'b0;
      run_first  = '0;
   endtask

   task automatic push_run(input logic [FRAME_W-1:0] first, input logic [FRAME_W-1:0] past,
                           input logic closed_at_end);
      run_report_type report;
      report.seg_start   = first;
      report.seg_end     = past;
      report.at_clip_end = closed_at_end;
      silent_runs_due.push_back(report);
   endtask

   // one frame through the energy window and silent-run tracker
   task automatic predict_frame(input logic signed [SAMPLE_BITS-1:0] l_smp,
                                input logic signed [SAMPLE_BITS-1:0] r_smp,
                                input logic last);
      logic signed [SUM_W-1:0] chan_sum;
      logic [SUM_W-1:0]        mag;
      logic [63:0]             square;
      logic [63:0]             total;
      logic [FRAME_W-1:0]      cur;
      logic [FRAME_W-1:0]      run_len;
      chan_sum = cfg_stereo ? (SUM_W'(l_smp) + SUM_W'(r_smp))
                            : (SUM_W'(l_smp) + SUM_W'(l_smp));
      mag      = chan_sum[SUM_W-1] ? -chan_sum : chan_sum;
      square   = 64'(mag) * 64'(mag);
      total    = 64'(acc_energy) + square;
      acc_energy = (total > 64'(ENERGY_FULL)) ? ENERGY_FULL : total[ENERGY_W-1:0];
      acc_fill   = acc_fill + FILL_W'(1);
      cur        = frame_no;
      // a zero length closes every frame, a lowered length closes on the next frame
      if (acc_fill >= cfg_window_len) begin
         if (acc_energy < cfg_threshold) begin
            if (!silent) begin
               silent    = 1'b1;
               run_first = win_first;
            end
         end else if (silent) begin
            run_len = win_first - run_first;
            if (run_len >= cfg_min_run)
               push_run(run_first, win_first, 1'b0);
            silent = 1'b0;
         end
         acc_energy = '0;
         acc_fill   = '0;
         win_first  = cur + FRAME_W'(1);
      end
      frame_no = cur + FRAME_W'(1);
      if (last) begin
         if (silent) begin
            run_len = frame_no - run_first;
            if (run_len >= cfg_min_run)
               push_run(run_first, frame_no, 1'b1);
         end
         clear_detector();
      end
   endtask

   task automatic check_report();
      run_report_type want;
      run_report_type got;
      got.seg_start   = rsp_tdata[OUT_W-1:0];
      got.seg_end     = rsp_tdata[2*OUT_W-1:OUT_W];
      got.at_clip_end = rsp_tuser;
      if (silent_runs_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected run report: start %0d end %0d at_clip_end %0b",
                     got.seg_start, got.seg_end, got.at_clip_end);
      end else begin
         want = silent_runs_due.pop_front();
         if (got.seg_start !== want.seg_start || got.seg_end !== want.seg_end ||
             got.at_clip_end !== want.at_clip_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"run report mismatch: expected start %0d end %0d at_clip_end %0b,",
                         " got start %0d end %0d at_clip_end %0b"},
                        want.seg_start, want.seg_end, want.at_clip_end,
                        got.seg_start, got.seg_end, got.at_clip_end);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_stereo     = STEREO_MODE_RESET;
         cfg_window_len = WINDOW_LEN_RESET;
         cfg_threshold  = ENERGY_THRESHOLD_RESET;
         cfg_min_run    = MIN_SILENCE_RESET;
         clear_detector();
         silent_runs_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_STEREO_MODE:      cfg_stereo     = csr_wdata[0];
               CSR_WINDOW_LEN:       cfg_window_len = csr_wdata[FILL_W-1:0];
               CSR_ENERGY_THRESHOLD: cfg_threshold  = csr_wdata[ENERGY_W-1:0];
               CSR_MIN_SILENCE:      cfg_min_run    = csr_wdata[MIN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_frame(req_tdata[SAMPLE_BITS-1:0], req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
                          req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_report();
      end
      reports_due <= silent_runs_due.size();
      error_count <= mismatches;
   end

endmodule

### tb/sv/windowed_energy_silence_detector_core_tb.sv
// Testbench top for windowed_energy_silence_detector_core: clock, reset, register
// writes and frame stimulus with random back-pressure; checking sits in wesd_run_checker.
// Depends on wesd_pkg, wesd_run_checker and the block itself.
module windowed_energy_silence_detector_core_tb;
   import wesd_pkg::*;

   localparam int RANDOM_FRAMES  = 900;
   localparam int SETTLE_CYCLES  = 24;    // lets frames that report nothing pass front, queue and square registers
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either stream

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_addr   = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata  = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [2*SAMPLE_BITS-1:0] req_tdata  = '0;  // left_sample, right_sample
   logic                     req_tlast  = 1'b0; // last_frame
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [2*OUT_W-1:0]       rsp_tdata;          // seg_start, seg_end
   logic                     rsp_tuser;          // at_clip_end

   int error_count;
   int reports_due;
   int frames_sent    = 0;
   int idle_cycles    = 0;
   int send_gap_pct   = 27;
   int recv_stall_pct = 85;

   windowed_energy_silence_detector_core uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   wesd_run_checker run_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .error_count (error_count),
      .reports_due (reports_due)
   );

   always #2 clock = ~clock;

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: a stuck handshake or a report that never shows ends the run here
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One frame transaction. Called at a falling edge, returns at the falling edge after
   // acceptance. tvalid stays high across back-to-back frames; it only drops for a gap.
   task automatic send_frame(input int l_smp, input int r_smp, input logic last);
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_tdata  <= {SAMPLE_BITS'(r_smp), SAMPLE_BITS'(l_smp)};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      frames_sent++;
      // idle profile: slow receiver, then slow sender, then full rate
      if (frames_sent < 300) begin
         send_gap_pct   = 27;
         recv_stall_pct = 85;
      end else if (frames_sent < 600) begin
         send_gap_pct   = 85;
         recv_stall_pct = 27;
      end else begin
         send_gap_pct   = 0;
         recv_stall_pct = 0;
      end
   endtask

   // Drain: no report outstanding, then enough cycles for frames that report nothing.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all four registers on an idle block. Bits above each register's width carry
   // random junk, which the block must drop.
   task automatic write_config(input logic stereo, input logic [FILL_W-1:0] wlen,
                               input logic [ENERGY_W-1:0] thr, input logic [MIN_W-1:0] min_run);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_STEREO_MODE;
      csr_wdata <= {junk[CSR_DATA_W-1:1], stereo};
      @(negedge clock);
      csr_addr  <= CSR_WINDOW_LEN;
      csr_wdata <= {junk[CSR_DATA_W-1:FILL_W], wlen};
      @(negedge clock);
      csr_addr  <= CSR_ENERGY_THRESHOLD;
      csr_wdata <= thr;
      @(negedge clock);
      csr_addr  <= CSR_MIN_SILENCE;
      csr_wdata <= {junk[CSR_DATA_W-1:MIN_W], min_run};
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random phase: one register setting, then a few clips. Most clips are built from whole
   // quiet or loud windows so silent runs open and close; some are pure noise, and a few
   // stop without a last frame so the detector state carries into the next setting.
   task automatic random_phase();
      int                  pick;
      int                  wlen;
      int                  span;
      int                  clips;
      int                  total;
      int                  mag;
      bit                  noisy;
      bit                  quiet;
      bit                  neg;
      bit                  closes;
      logic [ENERGY_W-1:0] thr;
      logic [MIN_W-1:0]    min_run;
      int                  l_smp;
      int                  r_smp;
      pick = $urandom_range(19);
      wlen = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(1, 6);
      span = (wlen == 0) ? 1 : wlen;
      // quiet frames stay at or under 144 per frame, loud ones at or over 40000
      pick = $urandom_range(11);
      thr  = (pick == 0) ? '0 : (pick == 1) ? '1 : ENERGY_W'(span * 300);
      pick = $urandom_range(11);
      min_run = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom_range(0, 4 * span);
      write_config(1'($urandom_range(1)), FILL_W'(wlen), thr, min_run);
      clips = (wlen == 65535) ? 1 : $urandom_range(1, 4);
      repeat (clips) begin
         // the longest window only ever sees a short clip, so it is dropped as partial
         noisy  = (wlen == 65535) || ($urandom_range(99) < 15);
         closes = ($urandom_range(99) < 90);
         total  = noisy ? $urandom_range(1, 20)
                        : $urandom_range(1, 8) * span + $urandom_range(0, span - 1);
         quiet  = 1'b1;
         for (int k = 0; k < total; k++) begin
            if (k % span == 0)
               quiet = ($urandom_range(99) < 60);
            if (noisy) begin
               l_smp = $urandom;
               r_smp = $urandom;
            end else if (quiet) begin
               l_smp = $urandom_range(0, 12) - 6;
               r_smp = $urandom_range(0, 12) - 6;
            end else begin
               neg   = 1'($urandom_range(1));
               mag   = $urandom_range(100, 32767);
               l_smp = neg ? -mag : mag;
               if (neg && $urandom_range(7) == 0)
                  l_smp = -32768;
               mag   = $urandom_range(100, 32767);
               r_smp = neg ? -mag : mag;
            end
            send_frame(l_smp, r_smp, closes && (k == total - 1));
         end
      end
   endtask

   initial begin
      int random_end;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: stereo, two-frame windows, threshold 100, any run length reported.
      // Silent window, full-scale loud window, window just under threshold, window exactly
      // at threshold (not silent), then a trailing run closed by the last frame.
      write_config(1'b1, 16'd2, 48'd100, 32'd0);
      send_frame(0, 0, 1'b0);
      send_frame(1, -1, 1'b0);
      send_frame(32767, 32767, 1'b0);
      send_frame(-32768, -32768, 1'b0);
      send_frame(5, 0, 1'b0);
      send_frame(-4, -3, 1'b0);
      send_frame(6, 4, 1'b0);
      send_frame(0, 0, 1'b0);
      send_frame(0, 0, 1'b0);
      send_frame(0, 0, 1'b0);
      send_frame(1, 1, 1'b1);

      // Mono with zero window length: each frame is a window, the right sample is ignored.
      write_config(1'b0, 16'd0, 48'd1, 32'd2);
      send_frame(0, 32767, 1'b0);
      send_frame(0, -32768, 1'b0);
      send_frame(1, 0, 1'b0);
      send_frame(-32768, 5, 1'b0);
      send_frame(0, 0, 1'b0);
      send_frame(0, 0, 1'b1);

      // Longest window with max threshold and max run length: partial window dropped.
      write_config(1'b1, 16'hFFFF, '1, '1);
      send_frame(32767, -32768, 1'b0);
      send_frame(-1, -1, 1'b1);

      // Window length lowered mid-window: the open window closes on the next frame.
      write_config(1'b1, 16'd8, '1, 32'd0);
      repeat (5) send_frame(3, 3, 1'b0);
      write_config(1'b1, 16'd3, '1, 32'd0);
      send_frame(0, 0, 1'b0);
      send_frame(7, 7, 1'b0);
      send_frame(1, 1, 1'b1);

      random_end = frames_sent + RANDOM_FRAMES;
      while (frames_sent < random_end)
         random_phase();

      drain();
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/wesd_pkg.sv
rtl/wesd_front.sv
rtl/wesd_queue.sv
rtl/wesd_back.sv
rtl/windowed_energy_silence_detector_core.sv
tb/sv/wesd_run_checker.sv
tb/sv/windowed_energy_silence_detector_core_tb.sv
